### rtl/core/ssm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared constants, types and the segment table of the seven-segment
// number multiplexer.
// ----------------------------------------------------------------------------
package ssm_pkg;

	localparam int unsigned REPEAT_MAX  = 15;
	localparam int unsigned REP_W       = $clog2(REPEAT_MAX + 1);
	localparam int unsigned VALUE_LIMIT = 9999;
	localparam int unsigned VALUE_W     = 16;
	localparam int unsigned BIN_W       = 14;
	localparam int unsigned BCD_W       = 16;
	localparam int unsigned NUM_DIGITS  = 4;
	localparam int unsigned DIG_W       = $clog2(NUM_DIGITS);

	typedef logic [7:0] seg_t;

	typedef struct packed {
		seg_t [NUM_DIGITS-1:0] pat;  // 0 ones, 1 hundreds, 2 tens, 3 thousands
		logic                  ovf;
		logic [REP_W-1:0]      reps;
	} entry_t;

	function automatic seg_t seg_of(input logic [3:0] d);
		seg_t s;
		unique case (d)
			4'd0:    s = 8'h3f;
			4'd1:    s = 8'h06;
			4'd2:    s = 8'h5b;
			4'd3:    s = 8'h4f;
			4'd4:    s = 8'h66;
			4'd5:    s = 8'h6d;
			4'd6:    s = 8'h7d;
			4'd7:    s = 8'h07;
			4'd8:    s = 8'h7f;
			4'd9:    s = 8'h6f;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

### rtl/core/ssm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_front
// Accepts a transaction, saturates the value, converts it to four BCD
// digits one bit per cycle and builds the blanked segment patterns.
// ----------------------------------------------------------------------------
module ssm_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [ssm_pkg::VALUE_W-1:0] value,
	input  wire logic [3:0]                  repeat_count,
	output logic                             q_push,
	output ssm_pkg::entry_t                  q_data,
	input  wire logic                        q_full
);
	import ssm_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		CONV,
		SEND
	} state_t;

	state_t               state_q;
	logic [BIN_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [3:0]           cnt_q;
	logic                 ovf_q;
	logic [REP_W-1:0]     reps_q;

	logic [BIN_W-1:0]     val_c;
	logic                 ovf_c;
	logic [REP_W-1:0]     reps_c;
	logic [BCD_W-1:0]     adj_c;
	logic [3:0]           th, hu, te, on;
	logic                 blank_th, blank_hu, blank_te;

	always_comb begin
		ovf_c = (32'(value) > VALUE_LIMIT);
		val_c = ovf_c ? BIN_W'(VALUE_LIMIT) : value[BIN_W-1:0];
		if (32'(repeat_count) > REPEAT_MAX) begin
			reps_c = REP_W'(REPEAT_MAX);
		end else begin
			reps_c = REP_W'(repeat_count);
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			adj_c[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3
			                                            : bcd_q[i*4 +: 4];
		end
	end

	assign th = bcd_q[15:12];
	assign hu = bcd_q[11:8];
	assign te = bcd_q[7:4];
	assign on = bcd_q[3:0];

	assign blank_th = (th == 4'd0);
	assign blank_hu = blank_th && (hu == 4'd0);
	assign blank_te = blank_hu && (te == 4'd0);

	always_comb begin
		q_data.pat[0] = seg_of(on);
		q_data.pat[1] = blank_hu ? seg_t'(0) : seg_of(hu);
		q_data.pat[2] = blank_te ? seg_t'(0) : seg_of(te);
		q_data.pat[3] = blank_th ? seg_t'(0) : seg_of(th);
		q_data.ovf    = ovf_q;
		q_data.reps   = reps_q;
	end

	assign full   = (state_q != IDLE);
	assign q_push = (state_q == SEND) && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (push && (reps_c != '0)) begin
						bin_q   <= val_c;
						bcd_q   <= '0;
						ovf_q   <= ovf_c;
						reps_q  <= reps_c;
						cnt_q   <= '0;
						state_q <= CONV;
					end
				end
				CONV: begin
					bcd_q <= {adj_c[BCD_W-2:0], bin_q[BIN_W-1]};
					bin_q <= {bin_q[BIN_W-2:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(BIN_W - 1)) begin
						state_q <= SEND;
					end
				end
				SEND: begin
					if (!q_full) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/ssm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_queue
// Two-entry queue of converted items between the front and back parts.
// ----------------------------------------------------------------------------
module ssm_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr_en,
	input  wire ssm_pkg::entry_t wr_data,
	output logic                 full,
	input  wire logic            rd_en,
	output ssm_pkg::entry_t      rd_data,
	output logic                 empty
);
	import ssm_pkg::*;

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr, do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 2'd1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/ssm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssm_back
// Walks an item through its refresh passes into an output register read as
// a queue, one frame per cycle while that register is empty or popped.
// ----------------------------------------------------------------------------
module ssm_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ssm_pkg::entry_t q_data,
	input  wire logic            q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  wire logic            pop,
	output logic [3:0]           digit_select,
	output logic [7:0]           segments,
	output logic [11:0]          shift_word,
	output logic                 overflow,
	output logic                 last
);
	import ssm_pkg::*;

	entry_t             ent_q;
	logic               busy_q;
	logic [REP_W-1:0]   rep_q;
	logic [DIG_W-1:0]   dig_q;
	logic               valid_q;
	logic               advance;
	logic               fin;

	assign advance = !valid_q || pop;
	assign q_pop   = advance && !busy_q && !q_empty;
	assign fin     = (rep_q == ent_q.reps - REP_W'(1)) && (dig_q == DIG_W'(NUM_DIGITS - 1));

	assign empty      = !valid_q;
	assign shift_word = {digit_select, segments};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			valid_q <= 1'b0;
			rep_q   <= '0;
			dig_q   <= '0;
		end else if (advance) begin
			if (busy_q) begin
				valid_q      <= 1'b1;
				digit_select <= 4'(4'd1 << dig_q);
				segments     <= ent_q.pat[dig_q];
				overflow     <= ent_q.ovf;
				last         <= fin;
				dig_q        <= dig_q + DIG_W'(1);
				if (dig_q == DIG_W'(NUM_DIGITS - 1)) begin
					rep_q <= rep_q + REP_W'(1);
				end
				if (fin) begin
					busy_q <= 1'b0;
				end
			end else begin
				valid_q <= 1'b0;
				if (!q_empty) begin
					ent_q  <= q_data;
					busy_q <= 1'b1;
					rep_q  <= '0;
					dig_q  <= '0;
				end
			end
		end
	end

endmodule
`default_nettype wire

### rtl/core/seven_segment_number_multiplexer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// seven_segment_number_multiplexer_top
// Path: bit-serial BCD conversion in the front, then the queue and back
// stages; the front takes no new item until its current one is queued.
// Output: back emits one frame per cycle while its output is empty or
// popped, 4 * repeats frames per item, and reloads between items.
// Reset: asynchronous, clears all control state; no clearing pass.
// ----------------------------------------------------------------------------
module seven_segment_number_multiplexer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [15:0] value,
	input  wire logic [3:0]  repeat_count,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       digit_select,
	output logic [7:0]       segments,
	output logic [11:0]      shift_word,
	output logic             overflow,
	output logic             last
);
	import ssm_pkg::*;

	entry_t f_data, b_data;
	logic   f_push, f_full;
	logic   b_pop, b_empty;

	ssm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.value        (value),
		.repeat_count (repeat_count),
		.q_push       (f_push),
		.q_data       (f_data),
		.q_full       (f_full)
	);

	ssm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_push),
		.wr_data (f_data),
		.full    (f_full),
		.rd_en   (b_pop),
		.rd_data (b_data),
		.empty   (b_empty)
	);

	ssm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (b_data),
		.q_empty      (b_empty),
		.q_pop        (b_pop),
		.empty        (empty),
		.pop          (pop),
		.digit_select (digit_select),
		.segments     (segments),
		.shift_word   (shift_word),
		.overflow     (overflow),
		.last         (last)
	);

endmodule
`default_nettype wire
